FILE: rtl/mrhk_pkg.sv
// shared types and constants for the multi-row hash key table
package mrhk_pkg;
  localparam int ROWS = 5;
  localparam int ROW_LEN = 128;
  localparam int NUM_REGS = 5;
  localparam int KEY_W = 31;
  localparam int SLOT_W = $clog2(ROW_LEN);
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W = $clog2(ROWS * ROW_LEN);
  localparam int MOD_W = SLOT_W + 1;
  localparam int CFG_W = 8;
  localparam int IDX_W = 3;
  localparam int STATUS_W = 3;
  localparam int OUT_ROW_W = 3;
  localparam int OUT_SLOT_W = 7;
  localparam int Q_DEPTH = 2;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd5;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FREE   = 1'b1;

  typedef struct packed {
    logic             op;
    logic             invalid;
    logic [KEY_W-1:0] key;
  } task_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MOD, B_READ, B_CHECK, B_WRITE, B_OUT
  } back_state_t;
endpackage

FILE: rtl/mrhk_if.sv
// valid/ready channel interfaces for requests and results
interface mrhk_req_if;
  import mrhk_pkg::*;
  logic valid;
  logic ready;
  logic op;
  logic [KEY_W-1:0] key;
  modport source (output valid, op, key, input ready);
  modport sink (input valid, op, key, output ready);
endinterface

interface mrhk_res_if;
  import mrhk_pkg::*;
  logic valid;
  logic ready;
  logic [STATUS_W-1:0] status;
  logic [OUT_ROW_W-1:0] row;
  logic [OUT_SLOT_W-1:0] slot;
  modport source (output valid, status, row, slot, input ready);
  modport sink (input valid, status, row, slot, output ready);
endinterface

FILE: rtl/mrhk_front.sv
// front end: accepts requests, classifies them and queues them
module mrhk_front import mrhk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mrhk_req_if.sink    req,
  output task_t       q_data,
  output logic        q_valid,
  input  logic        q_take
);
  localparam int PTR_W = $clog2(Q_DEPTH);
  task_t              q_mem [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;
  logic               push, pop;

  assign req.ready = (count != (PTR_W+1)'(Q_DEPTH));
  assign push = req.valid && req.ready;
  assign pop = q_take && q_valid;
  assign q_valid = (count != '0);
  assign q_data = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{op: req.op, invalid: (req.key == '0), key: req.key};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end
endmodule

FILE: rtl/mrhk_mod.sv
// iterative key modulo unit, one quotient bit per cycle
module mrhk_mod import mrhk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  input  logic [MOD_W-1:0]  modulus,
  output logic              done,
  output logic [SLOT_W-1:0] rem
);
  localparam int CNT_W = $clog2(KEY_W + 1);
  logic [KEY_W-1:0] shreg;
  logic [MOD_W:0]   acc;
  logic [MOD_W-1:0] m;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MOD_W:0]   trial;

  always_comb begin
    trial = {acc[MOD_W-1:0], shreg[KEY_W-1]};
  end

  assign rem = acc[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        shreg <= key;
        acc <= '0;
        m <= modulus;
        cnt <= CNT_W'(KEY_W);
      end else if (busy) begin
        shreg <= {shreg[KEY_W-2:0], 1'b0};
        acc <= (trial >= {1'b0, m}) ? trial - {1'b0, m} : trial;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/mrhk_back.sv
// back end: probes the rows, updates the key memory and drives results
module mrhk_back import mrhk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  task_t                   q_data,
  input  logic                    q_valid,
  output logic                    q_take,
  input  logic [NUM_REGS*CFG_W-1:0] moduli,
  mrhk_res_if.source              res
);
  localparam int CLR_W = ADDR_W + 1;
  back_state_t state, state_next;
  logic [KEY_W-1:0]  mem [ROWS*ROW_LEN];
  logic [KEY_W-1:0]  rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, addr;
  logic [KEY_W-1:0]  wr_data;
  task_t             cur;
  logic [ROW_W-1:0]  r;
  logic [ROW_W-1:0]  mod_r;
  logic [SLOT_W-1:0] s;
  logic              have_empty;
  logic [ROW_W-1:0]  e_row;
  logic [SLOT_W-1:0] e_slot;
  logic [CLR_W-1:0]  clr;
  logic              clearing;
  logic              mod_start, mod_done;
  logic [SLOT_W-1:0] mod_rem;
  logic [KEY_W-1:0]  mod_key;
  logic [MOD_W-1:0]  cur_mod;
  logic [CFG_W-1:0]  raw;
  logic              last_row;
  logic [STATUS_W-1:0] o_status;
  logic [ROW_W-1:0]  o_row;
  logic [SLOT_W-1:0] o_slot;

  // row that the modulo unit starts on: the next row when leaving a check
  assign mod_r = (state == B_CHECK) ? r + 1'b1 : r;
  // key comes straight from the queue when starting from idle
  assign mod_key = (state == B_IDLE) ? q_data.key : cur.key;

  // effective modulus of the row being started
  always_comb begin
    raw = (32'(mod_r) < NUM_REGS) ? moduli[mod_r*CFG_W +: CFG_W] : CFG_W'(ROW_LEN);
    if (raw == '0) cur_mod = MOD_W'(1);
    else if (32'(raw) > ROW_LEN) cur_mod = MOD_W'(ROW_LEN);
    else cur_mod = MOD_W'(raw);
  end

  mrhk_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .key(mod_key),
    .modulus(cur_mod), .done(mod_done), .rem(mod_rem)
  );

  assign clearing = (clr != CLR_W'(ROWS*ROW_LEN));
  assign addr = ADDR_W'(r) * ADDR_W'(ROW_LEN) + ADDR_W'(s);
  assign last_row = (32'(r) == ROWS - 1);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (q_valid && !clearing) state_next = q_data.invalid ? B_OUT : B_MOD;
      B_MOD:   if (mod_done) state_next = B_READ;
      B_READ:  state_next = B_CHECK;
      B_CHECK: begin
        if (cur.op == OP_FREE) begin
          if (rd_data == cur.key || last_row) state_next = B_OUT;
          else state_next = B_MOD;
        end else if (!have_empty && rd_data == '0) begin
          state_next = last_row ? B_WRITE : B_MOD;
        end else if (rd_data == cur.key) begin
          state_next = B_OUT;
        end else begin
          state_next = last_row ? B_WRITE : B_MOD;
        end
      end
      B_WRITE: state_next = B_OUT;
      B_OUT:   if (res.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_take = (state == B_IDLE) && q_valid && !clearing;
    mod_start = (state == B_IDLE && q_valid && !clearing && !q_data.invalid) ||
                (state == B_CHECK && state_next == B_MOD);
    wr_en = 1'b0;
    wr_addr = addr;
    wr_data = '0;
    if (clearing) begin
      wr_en = 1'b1;
      wr_addr = clr[ADDR_W-1:0];
    end else if (state == B_CHECK && cur.op == OP_FREE && rd_data == cur.key) begin
      wr_en = 1'b1;
    end else if (state == B_WRITE && have_empty) begin
      wr_en = 1'b1;
      wr_addr = ADDR_W'(e_row) * ADDR_W'(ROW_LEN) + ADDR_W'(e_slot);
      wr_data = cur.key;
    end
  end

  assign res.valid = (state == B_OUT);
  assign res.status = o_status;
  assign res.row = OUT_ROW_W'(o_row);
  assign res.slot = OUT_SLOT_W'(o_slot);

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid && !clearing) begin
          cur <= q_data;
          have_empty <= 1'b0;
          o_status <= q_data.invalid ? ST_INVALID : ST_MISS;
          o_row <= '0;
          o_slot <= '0;
        end
      end
      B_MOD: if (mod_done) s <= mod_rem;
      B_CHECK: begin
        if (cur.op == OP_FREE) begin
          if (rd_data == cur.key) begin
            o_status <= ST_FREED; o_row <= r; o_slot <= s;
          end
        end else if (!have_empty && rd_data == '0) begin
          have_empty <= 1'b1; e_row <= r; e_slot <= s;
        end else if (rd_data == cur.key) begin
          o_status <= ST_FOUND; o_row <= r; o_slot <= s;
        end
      end
      B_WRITE: begin
        if (have_empty) begin
          o_status <= ST_INSERTED; o_row <= e_row; o_slot <= e_slot;
        end else begin
          o_status <= ST_FULL;
        end
      end
      default: ;
    endcase
    if (rst) begin
      state <= B_IDLE;
      clr <= '0;
      r <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr <= clr + 1'b1;
      if (state == B_OUT) r <= '0;
      else if (state == B_CHECK && state_next == B_MOD) r <= r + 1'b1;
    end
  end

  a_out_status: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.status <= ST_INVALID)) else $error("bad status");
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_take) else $error("request taken while clearing");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.status)))
    else $error("result dropped");
endmodule

FILE: rtl/multi_row_hash_key_table_unit.sv
// top level of the multi-row hash key table
// A table of 5 rows of 128 keys; row r hashes a key to slot (key mod row r's
// modulus). op 0 looks the key up, inserting it into the first empty probed
// slot if absent; op 1 frees the first matching slot; key zero returns
// status invalid. One result per request, in order. Each probed row takes
// a modulo in the 31-step serial modulo unit, a memory read and a check;
// invalid keys skip the probing and go straight to the result. After reset
// the key memory is cleared by a pass over all its entries during which
// no request is started (they queue in the two-entry front queue). Modulus
// writes only when idle: the user must keep to this, as the block itself
// does not enforce it.
module multi_row_hash_key_table_unit import mrhk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  mrhk_req_if.sink         req,
  mrhk_res_if.source       res,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  // row modulus registers
  logic [NUM_REGS*CFG_W-1:0] moduli;
  task_t q_data;
  logic  q_valid, q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      moduli <= {8'd103, 8'd107, 8'd109, 8'd113, 8'd127};
    end else if (cfg_we && 32'(cfg_index) < NUM_REGS) begin
      moduli[cfg_index*CFG_W +: CFG_W] <= cfg_data;
    end
  end

  // front: accept and classify requests
  mrhk_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_data(q_data), .q_valid(q_valid), .q_take(q_take)
  );

  // back: probe rows and deliver results
  mrhk_back u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid),
    .q_take(q_take), .moduli(moduli), .res(res)
  );
endmodule
